/* design/ffca_pkg.sv */
package ffca_pkg;

   localparam int ADDR_BITS    = 32;
   localparam int SIZE_BITS    = 32;
   localparam int MAX_CHUNKS   = 64;
   localparam int IDX_BITS     = $clog2(MAX_CHUNKS);
   localparam int CNT_BITS     = $clog2(MAX_CHUNKS + 1);
   localparam int HEADER_BYTES = 24;
   localparam int MIN_GROWTH   = 4096;
   localparam int NEED_BITS    = SIZE_BITS + 1;
   localparam int TOTAL_BITS   = SIZE_BITS + 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_ZERO_SIZE = 3'd1,
      STATUS_EXHAUSTED = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_UNKNOWN   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GROW_PREP,
      ST_GROW_COMMIT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [SIZE_BITS-1:0] payload_size;
      logic                 is_free;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic trivial_done;
      logic hit_take;
      logic miss_done;
      logic grow_prep;
      logic grow_commit;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic trivial;
      logic hit;
      logic scan_end;
      logic op_free;
      logic rsp_free;
   } stat_type;

endpackage

/* design/ffca_ctrl.sv */
module ffca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffca_pkg::stat_type stat,
   output ffca_pkg::cmd_type  cmd
);

   ffca_pkg::state_type state_ff;
   ffca_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffca_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ffca_pkg::ST_SCAN;
            end
         end
         ffca_pkg::ST_SCAN: begin
            if (stat.trivial || stat.hit) begin
               state_in = ffca_pkg::ST_REPLY;
            end else if (stat.scan_end) begin
               state_in = stat.op_free ? ffca_pkg::ST_REPLY : ffca_pkg::ST_GROW_PREP;
            end
         end
         ffca_pkg::ST_GROW_PREP: begin
            state_in = ffca_pkg::ST_GROW_COMMIT;
         end
         ffca_pkg::ST_GROW_COMMIT: begin
            state_in = ffca_pkg::ST_REPLY;
         end
         ffca_pkg::ST_REPLY: begin
            if (stat.rsp_free) begin
               state_in = ffca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffca_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ffca_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ffca_pkg::ST_SCAN: begin
            if (stat.trivial) begin
               cmd.trivial_done = 1'b1;
            end else if (stat.hit) begin
               cmd.hit_take = 1'b1;
            end else if (stat.scan_end) begin
               cmd.miss_done = stat.op_free;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ffca_pkg::ST_GROW_PREP: begin
            cmd.grow_prep = 1'b1;
         end
         ffca_pkg::ST_GROW_COMMIT: begin
            cmd.grow_commit = 1'b1;
         end
         ffca_pkg::ST_REPLY: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* design/ffca_dpath.sv */
module ffca_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [31:0]                     csr_wdata,
   input  logic                            req_op,
   input  logic [ffca_pkg::SIZE_BITS-1:0]  req_request_size,
   input  logic [ffca_pkg::ADDR_BITS-1:0]  req_release_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ffca_pkg::ADDR_BITS-1:0]  rsp_result_address,
   output logic [2:0]                      rsp_status,
   input  ffca_pkg::cmd_type               cmd,
   output ffca_pkg::stat_type              stat
);

   localparam int AB = ffca_pkg::ADDR_BITS;
   localparam int NB = ffca_pkg::NEED_BITS;
   localparam int TB = ffca_pkg::TOTAL_BITS;

   ffca_pkg::entry_type mem [ffca_pkg::MAX_CHUNKS];
   ffca_pkg::entry_type rd_data_ff;

   logic [AB-1:0]                     heap_base_ff;
   logic [AB-1:0]                     heap_limit_ff;
   logic                              op_ff;
   logic [NB-1:0]                     need_ff;
   logic [AB-1:0]                     addr_ff;
   logic                              zero_size_ff;
   logic [ffca_pkg::CNT_BITS-1:0]     rd_idx_ff;
   logic [ffca_pkg::IDX_BITS-1:0]     cmp_idx_ff;
   logic                              cmp_valid_ff;
   logic [ffca_pkg::CNT_BITS-1:0]     count_ff;
   logic [AB-1:0]                     brk_ff;
   logic                              brk_known_ff;
   logic [TB-1:0]                     total_ff;
   logic [AB-1:0]                     res_addr_ff;
   ffca_pkg::status_type              res_status_ff;
   logic                              rsp_valid_ff;
   logic [AB-1:0]                     rsp_addr_ff;
   ffca_pkg::status_type              rsp_status_ff;

   logic [NB-1:0]  need_in;
   logic [TB-1:0]  total_raw;
   logic [TB-1:0]  total_in;
   logic [AB-1:0]  payload_addr;
   logic           match;
   logic           table_full;
   logic [TB-1:0]  avail;
   logic           grow_fail;
   logic [AB-1:0]  new_brk;
   logic [AB-1:0]  new_payload;
   logic [AB-1:0]  brk_payload;

   assign need_in = ({1'b0, req_request_size} + NB'(15)) & ~NB'(15);
   assign total_raw = ({1'b0, need_ff} + TB'(ffca_pkg::HEADER_BYTES + 15)) & ~TB'(15);
   assign total_in = (total_raw < TB'(ffca_pkg::MIN_GROWTH)) ?
                     TB'(ffca_pkg::MIN_GROWTH) : total_raw;

   assign payload_addr = rd_data_ff.base + AB'(ffca_pkg::HEADER_BYTES);
   assign match = (op_ff == ffca_pkg::OP_FREE) ?
                  (payload_addr == addr_ff) :
                  (rd_data_ff.is_free && ({1'b0, rd_data_ff.payload_size} >= need_ff));

   assign table_full  = (count_ff == ffca_pkg::CNT_BITS'(ffca_pkg::MAX_CHUNKS));
   assign avail       = {2'b00, heap_limit_ff} - {2'b00, brk_ff};
   assign grow_fail   = (brk_ff > heap_limit_ff) || (total_ff > avail);
   assign new_brk     = brk_ff + total_ff[AB-1:0];
   assign new_payload = total_ff[AB-1:0] - AB'(ffca_pkg::HEADER_BYTES);
   assign brk_payload = brk_ff + AB'(ffca_pkg::HEADER_BYTES);

   assign stat.trivial  = (op_ff == ffca_pkg::OP_FREE) ? (addr_ff == '0) : zero_size_ff;
   assign stat.hit      = cmp_valid_ff && match;
   assign stat.scan_end = (rd_idx_ff == count_ff) && !cmp_valid_ff;
   assign stat.op_free  = (op_ff == ffca_pkg::OP_FREE);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= '0;
         heap_limit_ff <= '1;
      end else if (csr_we) begin
         case (csr_index)
            ffca_pkg::CSR_HEAP_BASE:  heap_base_ff  <= csr_wdata[AB-1:0];
            ffca_pkg::CSR_HEAP_LIMIT: heap_limit_ff <= csr_wdata[AB-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         need_ff      <= need_in;
         addr_ff      <= req_release_address;
         zero_size_ff <= (req_request_size == '0);
      end
      if (cmd.grow_prep) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (rd_idx_ff != count_ff) begin
            rd_idx_ff    <= rd_idx_ff + 1'b1;
            cmp_valid_ff <= 1'b1;
         end else begin
            cmp_valid_ff <= 1'b0;
         end
      end else begin
         cmp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         cmp_idx_ff <= rd_idx_ff[ffca_pkg::IDX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_take) begin
         mem[cmp_idx_ff] <= '{base: rd_data_ff.base,
                              payload_size: rd_data_ff.payload_size,
                              is_free: op_ff};
      end else if (cmd.grow_commit && !table_full && !grow_fail) begin
         mem[count_ff[ffca_pkg::IDX_BITS-1:0]] <= '{base: brk_ff,
                                                    payload_size: new_payload,
                                                    is_free: 1'b0};
      end
      rd_data_ff <= mem[rd_idx_ff[ffca_pkg::IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         brk_ff       <= '0;
         brk_known_ff <= 1'b0;
      end else if (cmd.grow_prep) begin
         if (!brk_known_ff) begin
            brk_ff       <= heap_base_ff;
            brk_known_ff <= 1'b1;
         end
      end else if (cmd.grow_commit && !table_full && !grow_fail) begin
         count_ff <= count_ff + 1'b1;
         brk_ff   <= new_brk;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trivial_done) begin
         res_addr_ff   <= '0;
         res_status_ff <= (op_ff == ffca_pkg::OP_FREE) ?
                          ffca_pkg::STATUS_OK : ffca_pkg::STATUS_ZERO_SIZE;
      end else if (cmd.hit_take) begin
         res_addr_ff   <= (op_ff == ffca_pkg::OP_FREE) ? '0 : payload_addr;
         res_status_ff <= ffca_pkg::STATUS_OK;
      end else if (cmd.miss_done) begin
         res_addr_ff   <= '0;
         res_status_ff <= ffca_pkg::STATUS_UNKNOWN;
      end else if (cmd.grow_commit) begin
         if (table_full) begin
            res_addr_ff   <= '0;
            res_status_ff <= ffca_pkg::STATUS_FULL;
         end else if (grow_fail) begin
            res_addr_ff   <= '0;
            res_status_ff <= ffca_pkg::STATUS_EXHAUSTED;
         end else begin
            res_addr_ff   <= brk_payload;
            res_status_ff <= ffca_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ffca_pkg::CNT_BITS'(ffca_pkg::MAX_CHUNKS))
      else $error("chunk count beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_idx_ff <= count_ff)
      else $error("scan index past chunk count");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_take |-> cmp_valid_ff)
      else $error("hit taken without compared entry");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

   a_brk_known: assert property (@(posedge clock) disable iff (reset)
      cmd.grow_prep |=> brk_known_ff)
      else $error("break not loaded before growth");

endmodule

/* design/first_fit_chunk_allocator.sv */
// First-fit chunk allocator.
// Input channel (req_*): one word per request; req_op selects allocate or
// free, with req_request_size or req_release_address as the operand.
// Result channel (rsp_*): exactly one word per request, in request order,
// carrying the granted payload address and a status code.
// csr_*: heap_base (index 0) and heap_limit (index 1), which the user must
// write only while idle; the block does not enforce this. The chunk table is
// read one entry per cycle on a single port. A request is served by a scan
// of the table; when an allocate finds no free chunk, grow-prepare and
// grow-commit try to extend the heap. The result goes to the output register
// and rsp_valid rises. A zero-size allocate or a null free skips the scan.
// Requests are taken one at a time: req_ready is high only between requests.
// The result sits in an output register, so the next request is accepted and
// scanned while rsp_ready is low; it waits only to deliver its own result.
// Reset empties the chunk table, clears the break and restores heap_base to
// zero and heap_limit to all ones; no clearing pass is needed.
module first_fit_chunk_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [31:0]                     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [ffca_pkg::SIZE_BITS-1:0]  req_request_size,
   input  logic [ffca_pkg::ADDR_BITS-1:0]  req_release_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ffca_pkg::ADDR_BITS-1:0]  rsp_result_address,
   output logic [2:0]                      rsp_status
);

   ffca_pkg::cmd_type  cmd;
   ffca_pkg::stat_type stat;

   ffca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffca_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_op              (req_op),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_address  (rsp_result_address),
      .rsp_status          (rsp_status),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule
